// ===== sv/gf15_pkg.sv =====
`default_nettype none
package gf15_pkg;

   localparam int unsigned ElemWidth = 15;
   localparam int unsigned ExpWidth  = 32;
   localparam int unsigned NumCells  = ExpWidth - 1;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_MUL = 2'd1;
   localparam logic [1:0] ACT_POW = 2'd2;

   typedef logic [ElemWidth-1:0] elem_type;
   typedef logic [NumCells-1:0]  expo_type;

   typedef struct packed {
      logic     valid;
      elem_type acc;
      elem_type base;
      expo_type expo;
   } stage_type;

   localparam elem_type ElemOne = elem_type'(1);

   // carry-less product reduced modulo x^15 + x + 1
   function automatic elem_type gf_mul(input elem_type x, input elem_type y);
      logic [2*ElemWidth-2:0] prod;
      logic [ElemWidth-2:0]   hi;
      prod = '0;
      for (int i = 0; i < ElemWidth; i++) begin
         if (y[i]) begin
            prod = prod ^ ((2*ElemWidth-1)'(x) << i);
         end
      end
      hi = prod[2*ElemWidth-2:ElemWidth];
      // x^15 == x + 1
      gf_mul = prod[ElemWidth-1:0] ^ {1'b0, hi} ^ {hi, 1'b0};
   endfunction

endpackage
`default_nettype wire

// ===== sv/gf15_req_if.sv =====
`default_nettype none
interface gf15_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        action;
   logic [gf15_pkg::ElemWidth-1:0]    operand_a;
   logic [gf15_pkg::ElemWidth-1:0]    operand_b;
   logic signed [gf15_pkg::ExpWidth-1:0] exponent;

   modport source (output valid, action, operand_a, operand_b, exponent, input ready);
   modport sink   (input valid, action, operand_a, operand_b, exponent, output ready);
endinterface
`default_nettype wire

// ===== sv/gf15_rsp_if.sv =====
`default_nettype none
interface gf15_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gf15_pkg::ElemWidth-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface
`default_nettype wire

// ===== sv/gf15_cell.sv =====
`default_nettype none
module gf15_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire gf15_pkg::stage_type stage_in,
   output gf15_pkg::stage_type      stage_out
);
   import gf15_pkg::*;

   logic     valid_ff, valid_in;
   elem_type acc_ff, acc_in;
   elem_type base_ff, base_in;
   expo_type expo_ff, expo_in;

   always_comb begin
      valid_in = stage_in.valid;
      acc_in   = stage_in.expo[0] ? gf_mul(stage_in.acc, stage_in.base) : stage_in.acc;
      base_in  = gf_mul(stage_in.base, stage_in.base);
      expo_in  = {1'b0, stage_in.expo[NumCells-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff  <= acc_in;
         base_ff <= base_in;
         expo_ff <= expo_in;
      end
   end

   assign stage_out = '{valid: valid_ff, acc: acc_ff, base: base_ff, expo: expo_ff};

endmodule
`default_nettype wire

// ===== sv/gf2_15_arith_unit_top.sv =====
`default_nettype none
// GF(2^15) arithmetic unit, polynomial basis, modulus x^15 + x + 1. Every word
// (add, multiply, power, or the unused code which answers 0) runs through a
// chain of 31 cells, one per exponent bit, each holding an accumulator, a base
// and the remaining exponent bits and doing one square and one conditional
// multiply. Every action takes the same path through all cells; the chain advances as a
// whole, so a new word is taken every cycle unless the result at the end of
// the chain is waiting to be taken, in which case the whole chain holds.
module gf2_15_arith_unit_top (
   input  wire logic    clock,
   input  wire logic    reset,
   gf15_req_if.sink     req_chan,
   gf15_rsp_if.source   rsp_chan
);
   import gf15_pkg::*;

   stage_type chain [0:NumCells];
   stage_type head;
   logic      advance;

   assign advance = !chain[NumCells].valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      head.valid = req_chan.valid;
      head.acc   = '0;
      head.base  = req_chan.operand_a;
      head.expo  = '0;
      unique case (req_chan.action)
         ACT_ADD: begin
            head.acc = req_chan.operand_a ^ req_chan.operand_b;
         end
         ACT_MUL: begin
            head.acc  = req_chan.operand_a;
            head.base = req_chan.operand_b;
            head.expo = expo_type'(1);
         end
         ACT_POW: begin
            head.acc = ElemOne;
            // negative exponent gives 1
            head.expo = req_chan.exponent[ExpWidth-1] ? '0
                                                      : req_chan.exponent[NumCells-1:0];
         end
         default: begin
            head.acc = '0;
         end
      endcase
   end

   assign chain[0] = head;

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      gf15_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   assign rsp_chan.valid  = chain[NumCells].valid;
   assign rsp_chan.result = chain[NumCells].acc;

endmodule
`default_nettype wire

// ===== sv/gf15_checker.sv =====
`default_nettype none
module gf15_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [gf15_pkg::ElemWidth-1:0] rsp_result
);

   // input side only stalls behind a blocked result word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a blocked result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result)))
      else $error("result word dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !req_valid) |=> req_ready || rsp_valid)
      else $error("empty output stage yet input not ready");

endmodule

bind gf2_15_arith_unit_top gf15_checker u_gf15_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_result (rsp_chan.result)
);
`default_nettype wire
